// ===== rtl/mcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Marching-cubes cell mesher package
// Shared constants, types, edge tables and the triangle case table.
// ----------------------------------------------------------------------------
`default_nettype none

package mcm_pkg;

  localparam int MAX_RES_X  = 64;
  localparam int MAX_RES_Y  = 64;
  localparam int MAX_LAYERS = 1024;
  localparam int INDEX_BITS = 24;

  localparam int XW  = $clog2(MAX_RES_X);
  localparam int YW  = $clog2(MAX_RES_Y);
  localparam int ZW  = $clog2(MAX_LAYERS);
  localparam int IW  = INDEX_BITS;
  localparam int LAYER_ROWS = MAX_RES_X * MAX_RES_Y;
  localparam int LAW = $clog2(LAYER_ROWS);

  localparam logic [IW-1:0] IDX_MAX = {IW{1'b1}};

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_TRI    = 1'b1;

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] id;
  } edge_ent_t;

  typedef edge_ent_t [3:0] layer_row_t;  // edges 4..7 of the cube below
  typedef edge_ent_t [2:0] row_row_t;    // edges 11, 6, 10 of the cube in the previous row

  typedef struct packed {
    logic           rd_en;
    logic           wr_en;
    logic [LAW-1:0] laddr;
    logic [XW-1:0]  raddr;
  } es_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DEC,
    ST_VSEL,
    ST_DIV,
    ST_VOUT,
    ST_TRI,
    ST_WB
  } mcm_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_PREP,
    DIV_RUN
  } div_state_e;

  typedef struct packed {
    logic [4:0]       vld;
    logic [14:0][3:0] edges;
  } tri_list_t;

  localparam logic [2:0] EDGE_END0 [12] = '{
    3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7, 3'd0, 3'd1, 3'd2, 3'd3
  };
  localparam logic [2:0] EDGE_END1 [12] = '{
    3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd6, 3'd7, 3'd4, 3'd4, 3'd5, 3'd6, 3'd7
  };

  // creation order of new edge vertices
  localparam logic [3:0] NEW_ORDER [8] = '{
    4'd4, 4'd8, 4'd9, 4'd7, 4'd11, 4'd5, 4'd6, 4'd10
  };

  function automatic logic is_fresh(logic [3:0] e, logic x0, logic y0);
    logic r;
    r = (e == 4'd5) || (e == 4'd6) || (e == 4'd10) ||
        (y0 && ((e == 4'd4) || (e == 4'd8) || (e == 4'd9))) ||
        (x0 && ((e == 4'd7) || (e == 4'd11)));
    return r;
  endfunction

  // Each entry is an ASCII string of hex edge digits, right aligned.
  localparam logic [119:0] TRI_STR [256] = '{
    "","083","019","183981","12a","08312a","92a029","2832a8a98",
    "3b2","0b28b0","19023b","1b219b98b","3a1ba3","0a108a8ba","3903b9ba9","98aa8b",
    "478","430734","019847","419471731","12a847","34730412a","92a902847","2a9297273794",
    "8473b2","b47b24204","90184723b","47b94b9b2921","3a13ba784","1ba14b1047b4",
    "47890b9bab03","47b4b99ba",
    "954","954083","054150","854835315","12a954","30812a495","52a542402","2a5325354348",
    "95423b","0b208b495","05401523b","21525828b485","a3ba13954","4950818a18ba",
    "54050b5bab03","54858aa8b",
    "978579","930953573","078017157","153357","978957a12","a12950530573","802825857a52",
    "2a5253357",
    "7957893b2","95797292027b","23b018178157","b21b17715","958857a13a3b",
    "5705097b010aba0","ba0b03a50807570","ba57b5",
    "a65","0835a6","9015a6","1831985a6","165261","165126308","965906026","598582526328",
    "23ba65","b08b20a65","01923b5a6","5a61929b298b","63b653513","08b0b50515b6",
    "3b6036065059","65969bb98",
    "5a6478","43047365a","1905a6847","a65197173794","612651478","125526304347",
    "847905065026","739794329596269",
    "3b2784a65","5a647242027b","01947823b5a6","9219b294b7b45a6","8473b53515b6",
    "51b5b610b7b404b","059065036b63847","65969b4797b9",
    "a4964a","4a649a083","a01a60640","83181686461a","149124264","308129249264","024426",
    "832824426",
    "a49a64b23","08228b49a4a6","3b201606461a","64161a48121b8b1","964936913b63",
    "8b1810b61914641","3b6360064","648b68",
    "7a678a89a","0730a709a67a","a671a7178180","a67a71173","126168189867",
    "269291679093739","780706602","732672",
    "23ba68a89867","20727b09767a9a7","1801781a767a23b","b21b17a61671",
    "896867916b63136","091b67","7807063b0b60","7b6",
    "76b","308b76","019b76","819831b76","a126b7","12a3086b7","2902a96b7","6b72a3a83a98",
    "723627","708760620","276237019","162186198876","a76a17137","a7617a187108",
    "03707a0a96a7","76a7a88a9",
    "684b86","36b306046","86b846901","946963931b36","6846b82a1","12a30b06b046",
    "4b846b0292a9","a93a32943b36463",
    "823842462","042462","190234246438","194142246","8138618466a1","a10a06604",
    "4634386a3039a93","a946a4",
    "49576b","083495b76","50154076b","b76834354315","954a1276b","6b712a083495",
    "76b54a42a402","348354325a52b76",
    "723762549","954086062687","362376150540","628687218485158","954a16176137",
    "16a176107870954","40a4a503a6a737a","76a7a854a48a",
    "6956b9b89","36b063056095","0b805b01556b","6b3635531","12a95b9b8b56",
    "0b306b09656912a","b85b56805a52025","6b36352a3a53",
    "589528562382","956960062","158180568382628","156216","13616a386569896",
    "a10a06950560","03856a","a56",
    "b5a75b","b5ab75830","5b75ab190","a75ab7981831","b12b71751","08312717572b",
    "9759279022b7","75272b592328982",
    "25a235375","820852875a25","9015a35373a2","982921872a25752","135375","087071175",
    "903935537","987597",
    "5845a8ab8","5045b05abb30","01984a8aba45","ab4a45b34941314","2512852b8458",
    "04b0b345b2b151b","0250592b5458b85","9452b3",
    "25a352345384","5a2524420","3a235a385458019","5a2524192942","845853351","045105",
    "845853905035","945",
    "4b749b9ab","0834979b79ab","1ab1b414074b","3143481a474bab4","4b79b492b912",
    "9749b791b2b1083","b74b42240","b74b42834324",
    "29a279237749","9a7974a27870207","37a3a274a1a040a","1a2874","491417713",
    "491417081871","403743","487",
    "9a8ab8","30939bb9a","01a0a88ab","31ab3a","12b1b99b8","30939b1292b9","02b80b","32b",
    "23828aa89","9a2092","23828a0181a8","1a2","138918","091","038",""
  };

  // Left-align the string and turn each character into an edge number.
  function automatic tri_list_t tri_decode(logic [119:0] s);
    tri_list_t   r;
    logic [3:0]  n;
    logic [6:0]  sh;
    logic [119:0] a;
    logic [7:0]  ch;
    n = '0;
    for (int i = 0; i < 15; i++) begin
      n = n + {3'b0, (s[8*i +: 8] != 8'h00)};
    end
    sh = {(4'd15 - n), 3'b000};
    a  = s << sh;
    for (int j = 0; j < 15; j++) begin
      ch = a[119 - 8*j -: 8];
      r.edges[j] = (ch <= 8'h39) ? 4'(ch - 8'h30) : 4'(ch - 8'h57);
    end
    for (int k = 0; k < 5; k++) begin
      r.vld[k] = (a[119 - 24*k -: 8] != 8'h00);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mcm_frac_div.sv =====
// ----------------------------------------------------------------------------
// Crossing fraction divider
// Bit-serial restoring divider for floor(65536*(thr-a)/(b-a)), ratio clamped to [0,1].
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_frac_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  input  logic signed [15:0] thr_i,
  output logic               done_o,
  output logic [16:0]        quot_o
);

  mcm_pkg::div_state_e state_q, state_d;

  logic signed [16:0] num_q, den_q;
  logic signed [16:0] num_raw, den_raw;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        dv_q;
  logic [16:0]        quot_q, quot_d;
  logic [3:0]         step_q, step_d;
  logic               done_q, done_d;
  logic signed [16:0] num_cl;
  logic [16:0]        r2;
  logic               ge;

  assign num_raw = 17'(thr_i) - 17'(a_i);
  assign den_raw = 17'(b_i) - 17'(a_i);

  always_comb begin
    if (num_q < 17'sd0) begin
      num_cl = '0;
    end else if (num_q > den_q) begin
      num_cl = den_q;
    end else begin
      num_cl = num_q;
    end
  end

  assign r2 = {rem_q, 1'b0};
  assign ge = (r2 >= {1'b0, dv_q});

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    step_d  = step_q;
    done_d  = 1'b0;
    unique case (state_q)
      mcm_pkg::DIV_IDLE: begin
        if (start_i) state_d = mcm_pkg::DIV_LOAD;
      end
      mcm_pkg::DIV_LOAD: begin
        state_d = mcm_pkg::DIV_PREP;
      end
      mcm_pkg::DIV_PREP: begin
        step_d = '0;
        quot_d = '0;
        rem_d  = num_cl[15:0];
        if (den_q == 17'sd0) begin
          done_d  = 1'b1;
          state_d = mcm_pkg::DIV_IDLE;
        end else if (num_cl == den_q) begin
          quot_d  = 17'h10000;
          done_d  = 1'b1;
          state_d = mcm_pkg::DIV_IDLE;
        end else begin
          state_d = mcm_pkg::DIV_RUN;
        end
      end
      mcm_pkg::DIV_RUN: begin
        rem_d  = ge ? 16'(r2 - {1'b0, dv_q}) : r2[15:0];
        quot_d = {quot_q[15:0], ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          done_d  = 1'b1;
          state_d = mcm_pkg::DIV_IDLE;
        end
      end
      default: state_d = mcm_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcm_pkg::DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    step_q <= step_d;
    if (state_q == mcm_pkg::DIV_IDLE && start_i) begin
      // sign fix so that the denominator is non-negative
      if (den_raw < 17'sd0) begin
        num_q <= -num_raw;
        den_q <= -den_raw;
      end else begin
        num_q <= num_raw;
        den_q <= den_raw;
      end
    end
    if (state_q == mcm_pkg::DIV_PREP) begin
      dv_q <= den_q[15:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== rtl/mcm_edge_store.sv =====
// ----------------------------------------------------------------------------
// Edge vertex store
// Layer and row memories of edge vertex indices, with a clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mcm_edge_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mcm_pkg::es_cmd_t    cmd_i,
  input  mcm_pkg::layer_row_t layer_wdata_i,
  input  mcm_pkg::row_row_t   row_wdata_i,
  output mcm_pkg::layer_row_t layer_rdata_o,
  output mcm_pkg::row_row_t   row_rdata_o,
  output logic                busy_o
);

  mcm_pkg::layer_row_t layer_mem [mcm_pkg::LAYER_ROWS];
  mcm_pkg::row_row_t   row_mem   [mcm_pkg::MAX_RES_X];

  logic [mcm_pkg::LAW-1:0] clr_q;
  logic                    busy_q;
  mcm_pkg::layer_row_t     layer_rd_q;
  mcm_pkg::row_row_t       row_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == mcm_pkg::LAW'(mcm_pkg::LAYER_ROWS - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      layer_mem[clr_q]                     <= '0;
      row_mem[clr_q[mcm_pkg::XW-1:0]]      <= '0;
    end else if (cmd_i.wr_en) begin
      layer_mem[cmd_i.laddr] <= layer_wdata_i;
      row_mem[cmd_i.raddr]   <= row_wdata_i;
    end
    if (cmd_i.rd_en) begin
      layer_rd_q <= layer_mem[cmd_i.laddr];
      row_rd_q   <= row_mem[cmd_i.raddr];
    end
  end

  assign layer_rdata_o = layer_rd_q;
  assign row_rdata_o   = row_rd_q;
  assign busy_o        = busy_q;

endmodule

`default_nettype wire

// ===== rtl/marching_cubes_cell_mesher.sv =====
// ----------------------------------------------------------------------------
// Marching-cubes cell mesher
// Case index, edge vertex reuse, crossing fractions and triangle emission.
// ----------------------------------------------------------------------------
// One cube is taken at a time. The user must send cubes in raster order; the
// block itself does not enforce it. An empty cube is accepted without leaving
// the idle state. Otherwise a cube emits V new edge vertices (up to 8) and then
// T triangles (up to 5); a vertex whose crossing lies on the edge's second
// corner skips the quotient loop. The bit-serial fraction divider produces one
// quotient bit per cycle, and output stalls hold the mesher in its output
// states. After reset the edge store runs a clearing pass over its 4096 layer
// rows during which no cube is taken; threshold writes are accepted throughout.
`default_nettype none

module marching_cubes_cell_mesher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        iso_threshold_we_i,
  input  logic [15:0] iso_threshold_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [5:0]  cube_x_i,
  input  logic [5:0]  cube_y_i,
  input  logic [9:0]  cube_z_i,
  input  logic [15:0] corner_0_i,
  input  logic [15:0] corner_1_i,
  input  logic [15:0] corner_2_i,
  input  logic [15:0] corner_3_i,
  input  logic [15:0] corner_4_i,
  input  logic [15:0] corner_5_i,
  input  logic [15:0] corner_6_i,
  input  logic [15:0] corner_7_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [3:0]  edge_number_o,
  output logic [5:0]  out_x_o,
  output logic [5:0]  out_y_o,
  output logic [9:0]  out_z_o,
  output logic [16:0] fraction_o,
  output logic [23:0] vertex_index_o,
  output logic [23:0] tri_a_o,
  output logic [23:0] tri_b_o,
  output logic [23:0] tri_c_o,
  output logic        last_o
);

  localparam int IW = mcm_pkg::IW;

  mcm_pkg::mcm_state_e state_q, state_d;

  logic signed [15:0] thr_q;
  logic [15:0]        corner_in [8];
  logic [15:0]        corner_q  [8];
  logic [5:0]         x_q, y_q;
  logic [9:0]         z_q;
  logic [7:0]         cidx_d, cidx_q;
  logic [11:0]        emask_d, emask_q;
  logic [119:0]       tri_raw_q;
  mcm_pkg::tri_list_t tri_q;
  logic [IW-1:0]      id_q [12];
  logic [11:0]        ok_q;
  logic [IW-1:0]      gat_id [12];
  logic [11:0]        gat_ok;
  mcm_pkg::edge_ent_t prev0_q, prev1_q;
  logic [IW-1:0]      cnt_q;
  logic [3:0]         slot_q;
  logic [2:0]         k_q;
  logic [16:0]        frac_q;

  logic               accept;
  logic               clr_busy;
  mcm_pkg::es_cmd_t   es_cmd;
  mcm_pkg::layer_row_t layer_rd, layer_wd;
  mcm_pkg::row_row_t  row_rd, row_wd;

  logic               slot_free;
  logic [3:0]         cur_e;
  logic               pending;
  logic               div_start, div_done;
  logic [16:0]        div_q;
  logic [3:0]         tbase;
  logic [3:0]         ea, eb, ec;
  logic               tri_last;
  logic               ld_vtx, ld_tri, do_wb, do_gather;

  // output register
  logic               ov_q;
  logic               kind_q, last_q;
  logic [3:0]         edge_q;
  logic [5:0]         ox_q, oy_q;
  logic [9:0]         oz_q;
  logic [16:0]        ofrac_q;
  logic [IW-1:0]      ovi_q, ta_q, tb_q, tc_q;

  assign corner_in[0] = corner_0_i;
  assign corner_in[1] = corner_1_i;
  assign corner_in[2] = corner_2_i;
  assign corner_in[3] = corner_3_i;
  assign corner_in[4] = corner_4_i;
  assign corner_in[5] = corner_5_i;
  assign corner_in[6] = corner_6_i;
  assign corner_in[7] = corner_7_i;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cidx_d[i] = ($signed(corner_in[i]) >= thr_q);
    end
    for (int e = 0; e < 12; e++) begin
      emask_d[e] = cidx_d[mcm_pkg::EDGE_END0[e]] ^ cidx_d[mcm_pkg::EDGE_END1[e]];
    end
  end

  assign accept    = in_valid_i && in_ready_o;
  assign slot_free = !ov_q || out_ready_i;

  assign cur_e   = mcm_pkg::NEW_ORDER[slot_q[2:0]];
  assign pending = mcm_pkg::is_fresh(cur_e, (x_q == 6'd0), (y_q == 6'd0)) && emask_q[cur_e];

  assign tbase    = {k_q, 1'b0} + {1'b0, k_q};
  assign ea       = tri_q.edges[tbase];
  assign eb       = tri_q.edges[tbase + 4'd2];
  assign ec       = tri_q.edges[tbase + 4'd1];
  assign tri_last = (k_q == 3'd4) || !tri_q.vld[k_q + 3'd1];

  // ---------------------------------------------------------------- control
  always_comb begin
    state_d   = state_q;
    in_ready_o = 1'b0;
    div_start = 1'b0;
    ld_vtx    = 1'b0;
    ld_tri    = 1'b0;
    do_wb     = 1'b0;
    do_gather = 1'b0;
    unique case (state_q)
      mcm_pkg::ST_IDLE: begin
        in_ready_o = !clr_busy;
        if (in_valid_i && !clr_busy && (cidx_d != 8'd0)) state_d = mcm_pkg::ST_RD;
      end
      mcm_pkg::ST_RD: begin
        do_gather = 1'b1;
        state_d   = mcm_pkg::ST_DEC;
      end
      mcm_pkg::ST_DEC: begin
        state_d = mcm_pkg::ST_VSEL;
      end
      mcm_pkg::ST_VSEL: begin
        if (slot_q == 4'd8) begin
          state_d = tri_q.vld[0] ? mcm_pkg::ST_TRI : mcm_pkg::ST_WB;
        end else if (pending) begin
          div_start = 1'b1;
          state_d   = mcm_pkg::ST_DIV;
        end
      end
      mcm_pkg::ST_DIV: begin
        if (div_done) state_d = mcm_pkg::ST_VOUT;
      end
      mcm_pkg::ST_VOUT: begin
        if (slot_free) begin
          ld_vtx  = 1'b1;
          state_d = mcm_pkg::ST_VSEL;
        end
      end
      mcm_pkg::ST_TRI: begin
        if (slot_free) begin
          ld_tri = 1'b1;
          if (tri_last) state_d = mcm_pkg::ST_WB;
        end
      end
      mcm_pkg::ST_WB: begin
        do_wb   = 1'b1;
        state_d = mcm_pkg::ST_IDLE;
      end
      default: state_d = mcm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mcm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- edge store
  always_comb begin
    es_cmd.rd_en = accept;
    es_cmd.wr_en = do_wb;
    if (accept) begin
      es_cmd.laddr = mcm_pkg::LAW'(cube_y_i * mcm_pkg::MAX_RES_X + cube_x_i);
      es_cmd.raddr = cube_x_i[mcm_pkg::XW-1:0];
    end else begin
      es_cmd.laddr = mcm_pkg::LAW'(y_q * mcm_pkg::MAX_RES_X + x_q);
      es_cmd.raddr = x_q[mcm_pkg::XW-1:0];
    end
    for (int k = 0; k < 4; k++) begin
      layer_wd[k].ok = ok_q[4+k];
      layer_wd[k].id = id_q[4+k];
    end
    row_wd[0].ok = ok_q[11];
    row_wd[0].id = id_q[11];
    row_wd[1].ok = ok_q[6];
    row_wd[1].id = id_q[6];
    row_wd[2].ok = ok_q[10];
    row_wd[2].id = id_q[10];
  end

  mcm_edge_store u_store (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (es_cmd),
    .layer_wdata_i (layer_wd),
    .row_wdata_i   (row_wd),
    .layer_rdata_o (layer_rd),
    .row_rdata_o   (row_rd),
    .busy_o        (clr_busy)
  );

  mcm_frac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     ($signed(corner_q[mcm_pkg::EDGE_END0[cur_e]])),
    .b_i     ($signed(corner_q[mcm_pkg::EDGE_END1[cur_e]])),
    .thr_i   (thr_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // reused edge vertices: below, previous row and left neighbour
  always_comb begin
    for (int e = 0; e < 12; e++) begin
      gat_id[e] = '0;
      gat_ok[e] = 1'b0;
    end
    for (int k = 0; k < 4; k++) begin
      if (emask_q[k]) begin
        gat_id[k] = layer_rd[k].id;
        gat_ok[k] = layer_rd[k].ok;
      end
    end
    if (y_q != 6'd0) begin
      if (emask_q[4]) begin
        gat_id[4] = row_rd[1].id;
        gat_ok[4] = row_rd[1].ok;
      end
      if (emask_q[8]) begin
        gat_id[8] = row_rd[0].id;
        gat_ok[8] = row_rd[0].ok;
      end
      if (emask_q[9]) begin
        gat_id[9] = row_rd[2].id;
        gat_ok[9] = row_rd[2].ok;
      end
    end
    if (x_q != 6'd0) begin
      if (emask_q[7]) begin
        gat_id[7] = prev1_q.id;
        gat_ok[7] = prev1_q.ok;
      end
      if (emask_q[11]) begin
        gat_id[11] = prev0_q.id;
        gat_ok[11] = prev0_q.ok;
      end
    end
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      cnt_q   <= '0;
      prev0_q <= '0;
      prev1_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (iso_threshold_we_i) thr_q <= $signed(iso_threshold_i);
      if (ld_vtx && (cnt_q != mcm_pkg::IDX_MAX)) cnt_q <= cnt_q + 1'b1;
      if (do_wb) begin
        prev0_q.ok <= ok_q[10];
        prev0_q.id <= id_q[10];
        prev1_q.ok <= ok_q[5];
        prev1_q.id <= id_q[5];
      end
      if (ld_vtx || ld_tri) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= cube_x_i;
      y_q     <= cube_y_i;
      z_q     <= cube_z_i;
      cidx_q  <= cidx_d;
      emask_q <= emask_d;
      for (int i = 0; i < 8; i++) corner_q[i] <= corner_in[i];
    end
    if (state_q == mcm_pkg::ST_RD) begin
      tri_raw_q <= mcm_pkg::TRI_STR[cidx_q];
    end
    if (state_q == mcm_pkg::ST_DEC) begin
      tri_q  <= mcm_pkg::tri_decode(tri_raw_q);
      slot_q <= '0;
      k_q    <= '0;
    end
    if (do_gather) begin
      for (int e = 0; e < 12; e++) id_q[e] <= gat_id[e];
      ok_q <= gat_ok;
    end
    if (state_q == mcm_pkg::ST_VSEL && slot_q != 4'd8 && !pending) begin
      slot_q <= slot_q + 4'd1;
    end
    if (state_q == mcm_pkg::ST_DIV && div_done) begin
      frac_q <= div_q;
    end
    if (ld_vtx) begin
      id_q[cur_e] <= cnt_q;
      ok_q[cur_e] <= 1'b1;
      slot_q      <= slot_q + 4'd1;
      kind_q  <= mcm_pkg::KIND_VERTEX;
      edge_q  <= cur_e;
      ox_q    <= x_q;
      oy_q    <= y_q;
      oz_q    <= z_q;
      ofrac_q <= frac_q;
      ovi_q   <= cnt_q;
      ta_q    <= '0;
      tb_q    <= '0;
      tc_q    <= '0;
      last_q  <= 1'b0;
    end
    if (ld_tri) begin
      k_q     <= k_q + 3'd1;
      kind_q  <= mcm_pkg::KIND_TRI;
      edge_q  <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
      ofrac_q <= '0;
      ovi_q   <= '0;
      // missing vertices read as all ones
      ta_q    <= ok_q[ea] ? id_q[ea] : mcm_pkg::IDX_MAX;
      tb_q    <= ok_q[eb] ? id_q[eb] : mcm_pkg::IDX_MAX;
      tc_q    <= ok_q[ec] ? id_q[ec] : mcm_pkg::IDX_MAX;
      last_q  <= tri_last;
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = kind_q;
  assign edge_number_o  = edge_q;
  assign out_x_o        = ox_q;
  assign out_y_o        = oy_q;
  assign out_z_o        = oz_q;
  assign fraction_o     = ofrac_q;
  assign vertex_index_o = ovi_q;
  assign tri_a_o        = ta_q;
  assign tri_b_o        = tb_q;
  assign tri_c_o        = tc_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

// ===== sim/tb_marching_cubes_cell_mesher.sv =====
// ----------------------------------------------------------------------------
// Marching-cubes cell mesher testbench
// Drives cubes with random handshake gaps and predicts every vertex and
// triangle from its own copy of the edge store and the index counter.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_marching_cubes_cell_mesher;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        kind;
    logic [3:0]  edge_no;
    logic [5:0]  x;
    logic [5:0]  y;
    logic [9:0]  z;
    logic [16:0] frac;
    logic [23:0] vidx;
    logic [23:0] ta;
    logic [23:0] tb;
    logic [23:0] tc;
    logic        last;
  } mesh_item_t;

  typedef logic signed [15:0] corners_t [8];

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        thr_we = 1'b0;
  logic [15:0] thr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [5:0]  cx = '0;
  logic [5:0]  cy = '0;
  logic [9:0]  cz = '0;
  logic [15:0] corner [8];
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic        kind_o, last_o;
  logic [3:0]  edge_number_o;
  logic [5:0]  out_x_o, out_y_o;
  logic [9:0]  out_z_o;
  logic [16:0] fraction_o;
  logic [23:0] vertex_index_o, tri_a_o, tri_b_o, tri_c_o;

  // predictor state
  logic signed [15:0] iso_level = '0;
  logic [23:0] layer_ids [mcm_pkg::MAX_RES_X*mcm_pkg::MAX_RES_Y*4];
  logic        layer_ok  [mcm_pkg::MAX_RES_X*mcm_pkg::MAX_RES_Y*4];
  logic [23:0] row_ids   [mcm_pkg::MAX_RES_X*3];
  logic        row_ok    [mcm_pkg::MAX_RES_X*3];
  logic [23:0] left_ids  [2];
  logic        left_ok   [2];
  logic [23:0] vertex_count = '0;

  mesh_item_t  expected_results [$];
  int          mismatches = 0;
  bit          out_stall_on = 1'b1;
  int          out_hold = 0;

  logic signed [15:0] vol [8][8][6];

  initial begin
    for (int i = 0; i < 8; i++) corner[i] = '0;
    foreach (layer_ok[i]) layer_ok[i] = 1'b0;
    foreach (row_ok[i]) row_ok[i] = 1'b0;
    left_ok[0] = 1'b0;
    left_ok[1] = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  marching_cubes_cell_mesher uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .iso_threshold_we_i (thr_we),
    .iso_threshold_i    (thr_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready_o),
    .cube_x_i           (cx),
    .cube_y_i           (cy),
    .cube_z_i           (cz),
    .corner_0_i         (corner[0]),
    .corner_1_i         (corner[1]),
    .corner_2_i         (corner[2]),
    .corner_3_i         (corner[3]),
    .corner_4_i         (corner[4]),
    .corner_5_i         (corner[5]),
    .corner_6_i         (corner[6]),
    .corner_7_i         (corner[7]),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready),
    .kind_o             (kind_o),
    .edge_number_o      (edge_number_o),
    .out_x_o            (out_x_o),
    .out_y_o            (out_y_o),
    .out_z_o            (out_z_o),
    .fraction_o         (fraction_o),
    .vertex_index_o     (vertex_index_o),
    .tri_a_o            (tri_a_o),
    .tri_b_o            (tri_b_o),
    .tri_c_o            (tri_c_o),
    .last_o             (last_o)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic logic [16:0] crossing_frac(int a, int b, int thr);
    longint num, den;
    num = thr - a;
    den = b - a;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (den == 0) return '0;
    if (num < 0) num = 0;
    if (num > den) num = den;
    return 17'((num << 16) / den);
  endfunction

  function automatic logic [3:0] hex_edge(logic [7:0] ch);
    return (ch <= "9") ? 4'(ch - "0") : 4'(ch - "a" + 10);
  endfunction

  function automatic void queue_expected(mesh_item_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  // Predicts the vertices and triangles of one accepted cube.
  function automatic void mesh_cube(logic [5:0] x, logic [5:0] y, logic [9:0] z,
                                    corners_t c);
    logic [7:0]   cidx;
    logic [11:0]  emask;
    logic [23:0]  id [16];
    logic         ok [16];
    logic         fresh [16];
    int           lb, rb, n, first, cnt;
    logic [119:0] s;
    logic [3:0]   e, ea, eb, ec;
    mesh_item_t   r;
    cidx = '0;
    emask = '0;
    for (int k = 0; k < 8; k++) cidx[k] = (c[k] >= iso_level);
    if (cidx == 8'h00) return;
    for (int k = 0; k < 12; k++)
      emask[k] = cidx[mcm_pkg::EDGE_END0[k]] ^ cidx[mcm_pkg::EDGE_END1[k]];
    for (int k = 0; k < 16; k++) begin
      id[k] = '0;
      ok[k] = 1'b0;
      fresh[k] = 1'b0;
    end
    lb = (int'(y) * mcm_pkg::MAX_RES_X + int'(x)) * 4;
    rb = int'(x) * 3;
    for (int k = 0; k < 4; k++)
      if (emask[k]) begin
        id[k] = layer_ids[lb+k];
        ok[k] = layer_ok[lb+k];
      end
    if (y != 0) begin
      if (emask[4]) begin id[4] = row_ids[rb+1]; ok[4] = row_ok[rb+1]; end
      if (emask[8]) begin id[8] = row_ids[rb];   ok[8] = row_ok[rb];   end
      if (emask[9]) begin id[9] = row_ids[rb+2]; ok[9] = row_ok[rb+2]; end
    end else begin
      fresh[4] = 1'b1; fresh[8] = 1'b1; fresh[9] = 1'b1;
    end
    if (x != 0) begin
      if (emask[7])  begin id[7] = left_ids[1];  ok[7] = left_ok[1];  end
      if (emask[11]) begin id[11] = left_ids[0]; ok[11] = left_ok[0]; end
    end else begin
      fresh[7] = 1'b1; fresh[11] = 1'b1;
    end
    fresh[5] = 1'b1; fresh[6] = 1'b1; fresh[10] = 1'b1;
    first = expected_results.size();
    for (int k = 0; k < 8; k++) begin
      e = mcm_pkg::NEW_ORDER[k];
      if (fresh[e] && emask[e]) begin
        id[e] = vertex_count;
        ok[e] = 1'b1;
        if (vertex_count != mcm_pkg::IDX_MAX) vertex_count++;
        r = '{mcm_pkg::KIND_VERTEX, e, x, y, z,
              crossing_frac(c[mcm_pkg::EDGE_END0[e]], c[mcm_pkg::EDGE_END1[e]], iso_level),
              id[e], 24'd0, 24'd0, 24'd0, 1'b0};
        queue_expected(r);
      end
    end
    s = mcm_pkg::TRI_STR[cidx];
    cnt = 0;
    for (int i = 0; i < 15; i++) if (s[8*i +: 8] != 8'h00) cnt++;
    // leftmost character sits in the highest occupied byte; b and c swap
    for (int j = 0; j + 2 < cnt; j += 3) begin
      ea = hex_edge(s[8*(cnt-1-j) +: 8]);
      ec = hex_edge(s[8*(cnt-2-j) +: 8]);
      eb = hex_edge(s[8*(cnt-3-j) +: 8]);
      r = '{mcm_pkg::KIND_TRI, 4'd0, 6'd0, 6'd0, 10'd0, 17'd0, 24'd0,
            ok[ea] ? id[ea] : mcm_pkg::IDX_MAX, ok[eb] ? id[eb] : mcm_pkg::IDX_MAX,
            ok[ec] ? id[ec] : mcm_pkg::IDX_MAX, 1'b0};
      queue_expected(r);
    end
    for (int k = 0; k < 4; k++) begin
      layer_ids[lb+k] = id[4+k];
      layer_ok[lb+k]  = ok[4+k];
    end
    row_ids[rb]   = id[11]; row_ok[rb]   = ok[11];
    row_ids[rb+1] = id[6];  row_ok[rb+1] = ok[6];
    row_ids[rb+2] = id[10]; row_ok[rb+2] = ok[10];
    left_ids[0] = id[10]; left_ok[0] = ok[10];
    left_ids[1] = id[5];  left_ok[1] = ok[5];
    n = expected_results.size();
    if (n > first) expected_results[n-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  // Output side: random stalls, compare each transaction with the oldest expectation.
  always @(posedge clk_i) begin
    int r;
    mesh_item_t w;
    if (rst_ni && out_valid_o && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", kind_o, 0);
      end else begin
        w = expected_results.pop_front();
        if (kind_o != w.kind) report_mismatch("kind", kind_o, w.kind);
        if (edge_number_o != w.edge_no) report_mismatch("edge", edge_number_o, w.edge_no);
        if (out_x_o != w.x) report_mismatch("x", out_x_o, w.x);
        if (out_y_o != w.y) report_mismatch("y", out_y_o, w.y);
        if (out_z_o != w.z) report_mismatch("z", out_z_o, w.z);
        if (fraction_o != w.frac) report_mismatch("fraction", fraction_o, w.frac);
        if (vertex_index_o != w.vidx) report_mismatch("vertex", vertex_index_o, w.vidx);
        if (tri_a_o != w.ta) report_mismatch("tri_a", tri_a_o, w.ta);
        if (tri_b_o != w.tb) report_mismatch("tri_b", tri_b_o, w.tb);
        if (tri_c_o != w.tc) report_mismatch("tri_c", tri_c_o, w.tc);
        if (last_o != w.last) report_mismatch("last", last_o, w.last);
      end
    end
    r = $urandom_range(99);
    if (out_hold > 0) begin
      out_ready <= 1'b0;
      out_hold--;
    end else if (!out_stall_on) out_ready <= 1'b1;
    else if (r < 60) out_ready <= 1'b1;
    else if (r < 97) out_ready <= 1'b0;
    else begin
      // occasional long stall
      out_hold = $urandom_range(40, 10);
      out_ready <= 1'b0;
    end
  end

  // Receiver stall pattern switched on and off now and then.
  initial begin
    forever begin
      repeat ($urandom_range(400, 100)) @(posedge clk_i);
      out_stall_on = ($urandom_range(3) != 0);
    end
  end

  task automatic send_cube(logic [5:0] x, logic [5:0] y, logic [9:0] z, corners_t c);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    cx <= x;
    cy <= y;
    cz <= z;
    for (int i = 0; i < 8; i++) corner[i] <= c[i];
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    mesh_cube(x, y, z, c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic signed [15:0] v);
    drain();
    thr_we <= 1'b1;
    thr_data <= v;
    @(posedge clk_i);
    iso_level = v;
    thr_we <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_sample();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7fff;
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    corners_t c;
    for (int i = 0; i < 8; i++) c[i] = 16'sd0;
    send_cube(6'd0, 6'd0, 10'd0, c);             // full cube at threshold 0
    for (int i = 0; i < 8; i++) c[i] = -16'sd1;
    send_cube(6'd1, 6'd0, 10'd0, c);             // empty cube
    // single inside corner, each in turn
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 8; i++) c[i] = 16'sh8000;
      c[k] = 16'sh7fff;
      send_cube(6'(k), 6'(k & 1), 10'(k >> 1), c);
    end
    for (int i = 0; i < 8; i++) c[i] = (i[0]) ? 16'sh7fff : 16'sh8000;
    send_cube(6'd63, 6'd63, 10'd1023, c);
    send_cube(6'd0, 6'd63, 10'd1023, c);
    for (int i = 0; i < 8; i++) c[i] = (i < 4) ? 16'sh0001 : -16'sh0001;
    send_cube(6'd5, 6'd5, 10'd2, c);             // reused edges hold no valid vertex
    for (int i = 0; i < 8; i++) c[i] = rand_sample();
    send_cube(6'd42, 6'd21, 10'd682, c);
    send_cube(6'd21, 6'd42, 10'd341, c);
  endtask

  // Raster scan of a coherent random volume so that edge reuse is exercised.
  task automatic test_volume_scan(int nx, int ny, int nz, int z0, bit pause_midway);
    corners_t c;
    int mid;
    mid = 0;
    for (int x = 0; x <= nx; x++)
      for (int y = 0; y <= ny; y++)
        for (int z = 0; z <= nz; z++)
          vol[x][y][z] = ($urandom_range(3) == 0) ? rand_sample()
                                                  : 16'($urandom_range(600) - 300);
    for (int z = 0; z < nz; z++)
      for (int y = 0; y < ny; y++)
        for (int x = 0; x < nx; x++) begin
          c[0] = vol[x][y][z];     c[1] = vol[x+1][y][z];
          c[2] = vol[x+1][y+1][z]; c[3] = vol[x][y+1][z];
          c[4] = vol[x][y][z+1];   c[5] = vol[x+1][y][z+1];
          c[6] = vol[x+1][y+1][z+1]; c[7] = vol[x][y+1][z+1];
          send_cube(6'(x), 6'(y), 10'(z + z0), c);
          mid++;
          if (pause_midway && mid == (nx * ny * nz) / 2) begin
            in_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge clk_i);
            @(posedge clk_i);
          end
        end
  endtask

  task automatic test_random_cubes(int count);
    corners_t c;
    for (int n = 0; n < count; n++) begin
      for (int i = 0; i < 8; i++) c[i] = rand_sample();
      send_cube(6'($urandom), 6'($urandom), 10'($urandom), c);
    end
  endtask

  task automatic test_threshold_extremes();
    corners_t c;
    set_threshold(16'sh8000);                    // every cube full
    for (int i = 0; i < 8; i++) c[i] = rand_sample();
    send_cube(6'd3, 6'd3, 10'd3, c);
    set_threshold(16'sh7fff);
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 8; i++) c[i] = ($urandom_range(1)) ? 16'sh7fff : rand_sample();
      send_cube(6'(k), 6'd0, 10'(k), c);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_volume_scan(4, 3, 3, 0, 1'b1);
    set_threshold(16'sd100);
    test_volume_scan(5, 4, 2, 10, 1'b0);
    test_threshold_extremes();
    set_threshold(-16'sd50);
    test_volume_scan(3, 3, 3, 20, 1'b0);
    test_random_cubes(10);
    set_threshold(16'($urandom_range(400) - 200));
    test_volume_scan(4, 4, 2, 0, 1'b0);
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("[marching_cubes_cell_mesher] OK");
    end else begin
      $display("[marching_cubes_cell_mesher] ERROR");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("[marching_cubes_cell_mesher] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
